/* rtl/hep_pkg.sv */
// ----------------------------------------------------------------------------
// hep_pkg
// shared constants and types of the huffman encoder with byte packer
// ----------------------------------------------------------------------------
package hep_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int CODE_W       = 32;
   localparam int LEN_W        = 6;
   localparam int BYTE_W       = 8;
   localparam int VB_W         = 4;
   localparam int SYM_W        = 8;
   localparam int TABLE_DEPTH  = 256;
   localparam int CODE_LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int ACC_W        = BYTE_W + CODE_W;
   localparam int CNT_W        = 6;

   // item opcodes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } pk_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [VB_W-1:0]   valid_bits;
      logic              is_pad_count;
      logic              last;
   } pk_result_type;

endpackage

/* rtl/hep_packer.sv */
// ----------------------------------------------------------------------------
// hep_packer
// msb-first bit buffer that turns looked-up codes into bytes, one per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module hep_packer import hep_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          append_pad,
   input  logic          item_valid,
   input  pk_item_type   item,
   output logic          item_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output pk_result_type rsp
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_FIN_BYTE,
      ST_FIN_PAD
   } state_type;

   state_type         state_ff, state_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [VB_W-1:0]   fin_k_ff, fin_k_in;
   logic              fin_pad_ff, fin_pad_in;
   logic              out_valid_ff, out_valid_in;
   pk_result_type     out_ff, out_in;

   logic              out_free;
   logic [6:0]        shift_amt;
   logic [CODE_W-1:0] code_left;
   logic [ACC_W-1:0]  code_wide;
   logic [CNT_W-1:0]  cnt_sum;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign item_ready = (state_ff == ST_IDLE);
   assign rsp_valid  = out_valid_ff;
   assign rsp        = out_ff;

   // left-align the code, then place it right behind the buffered bits
   assign shift_amt = 7'(CODE_W) - 7'(item.len);
   assign code_left = (item.len == '0) ? '0 : (item.code << shift_amt);
   assign code_wide = {code_left, {BYTE_W{1'b0}}} >> cnt_ff;
   assign cnt_sum   = cnt_ff + item.len;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      fin_k_in     = fin_k_ff;
      fin_pad_in   = fin_pad_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               case (item.opcode)
                  OP_ENCODE: begin
                     acc_in = acc_ff | code_wide;
                     cnt_in = cnt_sum;
                     if (cnt_sum > CNT_W'(BYTE_W)) begin
                        state_in = ST_EMIT;
                     end
                  end
                  OP_FINISH: begin
                     fin_k_in   = cnt_ff[VB_W-1:0];
                     fin_pad_in = append_pad;
                     if (cnt_ff != '0) begin
                        state_in = ST_FIN_BYTE;
                     end else if (append_pad) begin
                        state_in = ST_FIN_PAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in      = 1'b1;
               out_in.out_byte   = acc_ff[ACC_W-1 -: BYTE_W];
               out_in.valid_bits = VB_W'(BYTE_W);
               out_in.is_pad_count = 1'b0;
               out_in.last       = (cnt_ff <= CNT_W'(2 * BYTE_W));
               acc_in            = acc_ff << BYTE_W;
               cnt_in            = cnt_ff - CNT_W'(BYTE_W);
               if (cnt_ff <= CNT_W'(2 * BYTE_W)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIN_BYTE: begin
            if (out_free) begin
               out_valid_in        = 1'b1;
               out_in.out_byte     = acc_ff[ACC_W-1 -: BYTE_W];
               out_in.valid_bits   = fin_k_ff;
               out_in.is_pad_count = 1'b0;
               out_in.last         = !fin_pad_ff;
               acc_in              = '0;
               cnt_in              = '0;
               state_in            = fin_pad_ff ? ST_FIN_PAD : ST_IDLE;
            end
         end
         ST_FIN_PAD: begin
            if (out_free) begin
               out_valid_in        = 1'b1;
               out_in.out_byte     = {{(BYTE_W-VB_W){1'b0}}, VB_W'(BYTE_W) - fin_k_ff};
               out_in.valid_bits   = '0;
               out_in.is_pad_count = 1'b1;
               out_in.last         = 1'b1;
               acc_in              = '0;
               cnt_in              = '0;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         fin_pad_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         fin_pad_ff   <= fin_pad_in;
         out_valid_ff <= out_valid_in;
      end
      fin_k_ff <= fin_k_in;
      out_ff   <= out_in;
   end

   // buffer never holds more than a byte between items
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cnt_ff <= CNT_W'(BYTE_W)))
      else $error("bit buffer over one byte while idle");

   // emitting only while a byte is followed by more bits
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff > CNT_W'(BYTE_W)))
      else $error("emit state without a completed byte");

   // a pad count carries no code bits and closes its item
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.is_pad_count) |-> (out_ff.valid_bits == '0 && out_ff.last))
      else $error("malformed pad-count item");

   // a finish leaves an empty buffer once its results are loaded
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN_PAD && out_free) |=> (cnt_ff == '0))
      else $error("buffer not cleared after finish");

endmodule

/* rtl/huffman_encode_bit_packer_top.sv */
// ----------------------------------------------------------------------------
// huffman_encode_bit_packer_top
// huffman encoder with a 256-entry code table and an msb-first byte packer
// ----------------------------------------------------------------------------
// Usage: load every symbol's code with load items before encoding it, then
// send encode items and close each stream with a finish item. An encode
// completes 0 to 4 bytes and a finish gives 0 to 2 results. The packer
// sets the rate: it takes one item per cycle when no byte is due and gives
// at most one byte per cycle. The code table is a synchronous memory read at
// the edge that accepts the item, and its read register feeds the packer, so
// a lookup overlaps the previous item's byte output. An item waits in the
// lookup stage while the packer is busy, and a finished byte waits in the
// output register without blocking the next lookup. append_pad should be
// written only while idle.
// ----------------------------------------------------------------------------
module huffman_encode_bit_packer_top import hep_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // symbol[7:0], code_value[39:8], code_length[45:40]
   input  logic [1:0]  req_tuser,   // opcode[1:0]

   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], valid_bits[11:8]
   output logic        rsp_tuser,   // is_pad_count
   output logic        rsp_tlast,   // last result of the input item

   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // register decode: register 0 is append_pad
   localparam logic CSR_APPEND_PAD = 1'b0;

   logic                    append_pad_ff;
   logic                    csr_write;

   // input field split
   logic [1:0]              in_opcode;
   logic [SYM_W-1:0]        in_symbol;
   logic [CODE_W-1:0]       in_code;
   logic [LEN_W-1:0]        in_len;
   logic [LEN_W-1:0]        in_len_sat;

   // code table: code bits above the length field
   logic [CODE_W+LEN_W-1:0] code_mem [TABLE_DEPTH];
   logic [CODE_W+LEN_W-1:0] rd_ff;

   // lookup stage
   logic                    s1_valid_ff, s1_valid_in;
   logic [1:0]              s1_op_ff;
   logic                    req_accept;
   logic                    pk_ready;
   pk_item_type             pk_item;
   pk_result_type           pk_rsp;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_APPEND_PAD) ? {31'b0, append_pad_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         append_pad_ff <= 1'b1;
      end else if (csr_write && csr_paddr[2] == CSR_APPEND_PAD) begin
         append_pad_ff <= csr_pwdata[0];
      end
   end

   assign in_opcode  = req_tuser;
   assign in_symbol  = req_tdata[7:0];
   assign in_code    = req_tdata[39:8];
   assign in_len     = req_tdata[45:40];
   // lengths beyond the limit saturate, upper code bits are simply ignored
   assign in_len_sat = (in_len > LEN_W'(CODE_LEN_LIM)) ? LEN_W'(CODE_LEN_LIM) : in_len;

   // item moves on when the lookup stage is empty or hands over this cycle
   assign req_tready = !s1_valid_ff || pk_ready;
   assign req_accept = req_tvalid && req_tready;

   // a load writes at its accept edge and any later lookup reads at a later
   // edge, so read and write of one entry never meet in the same cycle
   always_ff @(posedge clock) begin
      if (req_accept && in_opcode == OP_LOAD) begin
         code_mem[in_symbol] <= {in_code, in_len_sat};
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_ff <= code_mem[in_symbol];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (pk_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_op_ff <= in_opcode;
      end
   end

   assign pk_item.opcode = s1_op_ff;
   assign pk_item.code   = rd_ff[CODE_W+LEN_W-1:LEN_W];
   assign pk_item.len    = rd_ff[LEN_W-1:0];

   hep_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .append_pad (append_pad_ff),
      .item_valid (s1_valid_ff),
      .item       (pk_item),
      .item_ready (pk_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (pk_rsp)
   );

   assign rsp_tdata = {4'b0, pk_rsp.valid_bits, pk_rsp.out_byte};
   assign rsp_tuser = pk_rsp.is_pad_count;
   assign rsp_tlast = pk_rsp.last;

endmodule

/* tb/tb_huffman_encode_bit_packer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_encode_bit_packer_top
// self-checking bench for the huffman encoder with byte packer: a queue-fed
// driver sends load, encode and finish items, an in-bench predictor of the
// code table and bit buffer works out the packed bytes and pad counts, and a
// monitor checks every result item in order under several idle patterns and
// both settings of append_pad
// ----------------------------------------------------------------------------
module tb_huffman_encode_bit_packer_top import hep_pkg::*; ();

   // opcode the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // register address of append_pad
   localparam logic [2:0] ADDR_APPEND_PAD = 3'd0;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [1:0]        opcode;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code_value;
      logic [LEN_W-1:0]  code_length;
   } enc_item_type;

   // ---------------------------------------------------------------- signals
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // symbol[7:0], code_value[39:8], code_length[45:40]
   logic [1:0]  req_tuser = OP_LOAD; // opcode[1:0]

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // out_byte[7:0], valid_bits[11:8]
   logic        rsp_tuser;         // is_pad_count
   logic        rsp_tlast;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   huffman_encode_bit_packer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------ bench state
   enc_item_type    pending_items[$];   // items waiting for the driver
   enc_item_type    bus_item;           // item currently on the request bus
   pk_result_type   expected_bytes[$];  // predicted results, oldest first
   int              sender_idle_pct = 0;
   int              receiver_stall_pct = 0;
   int              fail_count = 0;
   int              cycle_count = 0;

   // predictor copy of the block state
   logic [CODE_W-1:0] model_code[TABLE_DEPTH];
   logic [LEN_W-1:0]  model_len[TABLE_DEPTH];
   logic [7:0]        model_buf = '0;
   logic [3:0]        model_count = '0;
   logic              model_pad_mode = 1'b1;

   // stimulus side bookkeeping: only loaded symbols get encoded
   logic [SYM_W-1:0]  loaded_syms[$];
   bit                sym_loaded[TABLE_DEPTH];

   // ------------------------------------------------------------------ clock
   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------- predictor
   // appends one predicted result to the expectation queue
   function automatic void push_result(logic [7:0] b, logic [3:0] vb, logic pad);
      pk_result_type r;
      r.out_byte = b;
      r.valid_bits = vb;
      r.is_pad_count = pad;
      r.last = 1'b0;
      expected_bytes.insert(expected_bytes.size(), r);
   endfunction

   // works out the results of one accepted item and updates the model state
   function automatic void pack_predict(enc_item_type it);
      int unsigned len;
      int          n_before;
      int          k;
      logic [CODE_W-1:0] code;
      logic        b;
      n_before = expected_bytes.size();
      case (it.opcode)
         OP_LOAD: begin
            len = it.code_length;
            if (len > CODE_LEN_LIM) len = CODE_LEN_LIM;   // long codes saturate
            model_code[it.symbol] = it.code_value;
            model_len[it.symbol] = len[LEN_W-1:0];
         end
         OP_ENCODE: begin
            code = model_code[it.symbol];
            len = model_len[it.symbol];
            for (int i = len; i > 0; i--) begin
               b = code[i-1];
               // a full byte leaves only when one more bit shows up
               if (model_count >= 8) begin
                  push_result(model_buf, 4'd8, 1'b0);
                  model_buf = '0;
                  model_count = '0;
               end
               model_buf[7 - model_count] = b;
               model_count = model_count + 4'd1;
            end
         end
         OP_FINISH: begin
            k = (model_count > 8) ? 8 : model_count;
            if (k > 0) push_result(model_buf, k[3:0], 1'b0);
            if (model_pad_mode) push_result(8'(8 - k), 4'd0, 1'b1);
            model_buf = '0;
            model_count = '0;
         end
         default: ;   // unused opcode changes nothing
      endcase
      if (expected_bytes.size() > n_before)
         expected_bytes[expected_bytes.size()-1].last = 1'b1;
   endfunction

   // ----------------------------------------------------------------- driver
   // one nonblocking update per signal per edge; the accepted item is the
   // one held in bus_item before this edge
   always @(posedge clock) begin
      enc_item_type nxt;
      logic      drive;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         drive = req_tvalid && !req_tready;   // hold an item not yet taken
         nxt = bus_item;
         if (req_tvalid && req_tready) pack_predict(bus_item);
         if (!drive && pending_items.size() != 0 &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            nxt = pending_items.pop_front();
            drive = 1'b1;
         end
         req_tvalid <= drive;
         bus_item <= nxt;
         req_tuser <= nxt.opcode;
         req_tdata <= {2'b00, nxt.code_length, nxt.code_value, nxt.symbol};
      end
   end

   // ---------------------------------------------------------------- monitor
   function automatic void check_field(string fname, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, fname, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      pk_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $display({"%0t unexpected result: expected none ",
                         "actual byte %0d vb %0d pad %0b last %0b"},
                        $time, rsp_tdata[7:0], rsp_tdata[11:8], rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               check_field("out_byte", want.out_byte, rsp_tdata[7:0]);
               check_field("valid_bits", want.valid_bits, rsp_tdata[11:8]);
               check_field("is_pad_count", want.is_pad_count, rsp_tuser);
               check_field("last", want.last, rsp_tlast);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // -------------------------------------------------------------- stimulus
   function automatic void queue_item(logic [1:0] op, logic [7:0] sym,
                                      logic [31:0] code, logic [5:0] len);
      enc_item_type it;
      it.opcode = op;
      it.symbol = sym;
      it.code_value = code;
      it.code_length = len;
      if (op == OP_LOAD && !sym_loaded[sym]) begin
         sym_loaded[sym] = 1'b1;
         loaded_syms.insert(loaded_syms.size(), sym);
      end
      pending_items.insert(pending_items.size(), it);
   endfunction

   // mostly well-formed streams: loads, encodes of loaded symbols, finishes,
   // plus a little noise on the unused opcode
   function automatic void queue_random(int count);
      int pick;
      int lsel;
      logic [5:0] len;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            lsel = $urandom_range(0, 99);
            if (lsel < 5) len = 6'd0;
            else if (lsel < 15) len = 6'd32;
            else if (lsel < 22) len = 6'($urandom_range(33, 63));   // saturates
            else len = 6'($urandom_range(1, 12));
            queue_item(OP_LOAD, 8'($urandom_range(0, 255)), $urandom, len);
         end else if (pick < 85) begin
            queue_item(OP_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size()-1)],
                       $urandom, 6'($urandom_range(0, 63)));
         end else if (pick < 95) begin
            queue_item(OP_FINISH, 8'($urandom_range(0, 255)), $urandom,
                       6'($urandom_range(0, 63)));
         end else begin
            queue_item(OP_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                       6'($urandom_range(0, 63)));
            i--;   // ignored items do not count
         end
      end
   endfunction

   // checks run on the falling edge, after all rising-edge updates settled
   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_bytes.size() != 0)
         @(negedge clock);
      // a load at the tail gives no result but may still sit in the pipe
      repeat (10) @(negedge clock);
   endtask

   // setup cycle then access cycle; the write lands on the access edge
   task automatic write_append_pad(logic v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_APPEND_PAD;
      csr_pwdata <= {31'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      model_pad_mode = v;
      // read back the register once the write has landed
      @(negedge clock);
      check_field("csr_prdata", int'({31'd0, v}), int'(csr_prdata));
      check_field("csr_pready", 1, int'(csr_pready));
   endtask

   task automatic run_phase(logic pad, int idle_pct, int stall_pct, int count);
      write_append_pad(pad);
      @(negedge clock);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      queue_random(count);
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, pad mode from reset
      queue_item(OP_FINISH, 8'h00, 32'h0, 6'd0);              // empty stream, count of 8
      queue_item(OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0);       // zero-length code
      queue_item(OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);      // longest code
      queue_item(OP_LOAD, 8'h01, 32'h0000_0000, 6'd63);      // saturated to all zeros
      queue_item(OP_LOAD, 8'h02, 32'hA5A5_A5A5, 6'd33);      // saturated
      queue_item(OP_LOAD, 8'h03, 32'hFFFF_FFFE, 6'd1);       // one zero bit, upper ignored
      queue_item(OP_LOAD, 8'h04, 32'h0000_0001, 6'd1);
      queue_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);             // appends nothing
      queue_item(OP_ENCODE, 8'h04, 32'h0, 6'd0);             // one bit, no result
      queue_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);             // four bytes at once
      queue_item(OP_ENCODE, 8'h01, 32'h0, 6'd0);             // four bytes, zero but for the carried bit
      queue_item(OP_FINISH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);    // partial byte and pad count
      queue_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);    // ignored
      for (int i = 0; i < 4; i++) begin
         queue_item(OP_ENCODE, 8'h04, 32'h0, 6'd0);
         queue_item(OP_ENCODE, 8'h03, 32'h0, 6'd0);
      end
      queue_item(OP_FINISH, 8'h00, 32'h0, 6'd0);             // exact byte, pad count 0
      wait_drained();

      // directed part without padding
      write_append_pad(1'b0);
      @(negedge clock);
      queue_item(OP_FINISH, 8'h00, 32'h0, 6'd0);             // empty stream, nothing
      queue_item(OP_ENCODE, 8'h04, 32'h0, 6'd0);
      queue_item(OP_FINISH, 8'h00, 32'h0, 6'd0);             // one bit left-aligned
      queue_item(OP_ENCODE, 8'h02, 32'h0, 6'd0);
      queue_item(OP_FINISH, 8'h00, 32'h0, 6'd0);
      wait_drained();

      // random phases under the different idle patterns
      run_phase(1'b1, 0, 0, 50);
      run_phase(1'b0, 72, 0, 50);
      run_phase(1'b1, 0, 72, 50);
      run_phase(1'b0, 15, 15, 50);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
